// ===== rtl/core/spi_pkg.sv =====
// Shared types and constants for the segment/polygon intersection unit.
// Used by spi_ctrl, spi_dp, the top level and the testbench.
package spi_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_WIDTH_DEF  = 32;
	localparam int FIELD_W          = 32;

	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_POINT  = 2'd1;
	localparam logic [1:0] KIND_SEG    = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	localparam logic [1:0] PH_CR = 2'd0;
	localparam logic [1:0] PH_TN = 2'd1;
	localparam logic [1:0] PH_UN = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APPEND,
		ST_PRIME,
		ST_LATCHP,
		ST_CUR,
		ST_OPR,
		ST_MUL,
		ST_SUB,
		ST_EVAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       latch_query;
		logic       wr;
		logic       clr_par;
		logic       latch_prev;
		logic       latch_cur;
		logic       shift_prev;
		logic       op_load;
		logic       mul;
		logic       sub;
		logic       eval;
		logic       seg;
		logic       mid;
		logic [1:0] ph;
	} cmd_t;

	typedef struct packed {
		logic seg_cross;
		logic par_next;
	} stat_t;

endpackage

// ===== rtl/core/spi_ctrl.sv =====
// Controller for the segment/polygon intersection unit: handshakes, vertex
// count, edge walk sequencing and the output register. Depends on spi_pkg.
module spi_ctrl #(
	parameter int MAX_VERTICES = spi_pkg::MAX_VERTICES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        kind,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic                              status,
	output spi_pkg::cmd_t                     cmd,
	input  spi_pkg::stat_t                    stat,
	output logic [$clog2(MAX_VERTICES)-1:0]   waddr,
	output logic [$clog2(MAX_VERTICES)-1:0]   raddr
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	spi_pkg::state_t state_q, state_n;
	logic [1:0]    kind_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_n;
	logic [CW-1:0] last;
	logic [1:0]    ph_q;
	logic          seg_q;
	logic          mid_q;
	logic          res_hit_q;
	logic          res_status_q;
	logic          out_valid_q;
	logic          hit_q;
	logic          status_q;
	logic          accept;
	logic          full;
	logic          slot_free;
	logic          walk_end;

	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CW'(MAX_VERTICES));
	assign slot_free = !out_valid_q || out_ready;
	assign idx_n     = idx_q + 1'b1;
	assign last      = count_q - 1'b1;
	assign walk_end  = (idx_n == count_q);
	assign waddr     = count_q[AW-1:0];

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			spi_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (kind) inside
						spi_pkg::KIND_APPEND: state_n = spi_pkg::ST_APPEND;
						spi_pkg::KIND_POINT,
						spi_pkg::KIND_SEG:
							state_n = (count_q == '0) ? spi_pkg::ST_DONE : spi_pkg::ST_PRIME;
						default: state_n = spi_pkg::ST_DONE;
					endcase
				end
			end
			spi_pkg::ST_APPEND: state_n = spi_pkg::ST_DONE;
			spi_pkg::ST_PRIME:  state_n = spi_pkg::ST_LATCHP;
			spi_pkg::ST_LATCHP: state_n = spi_pkg::ST_CUR;
			spi_pkg::ST_CUR:    state_n = spi_pkg::ST_OPR;
			spi_pkg::ST_OPR:    state_n = spi_pkg::ST_MUL;
			spi_pkg::ST_MUL:    state_n = spi_pkg::ST_SUB;
			spi_pkg::ST_SUB: begin
				if (seg_q && ph_q != spi_pkg::PH_UN)
					state_n = spi_pkg::ST_OPR;
				else
					state_n = spi_pkg::ST_EVAL;
			end
			spi_pkg::ST_EVAL: begin
				if (seg_q && stat.seg_cross)
					state_n = spi_pkg::ST_DONE;
				else if (walk_end)
					state_n = seg_q ? spi_pkg::ST_PRIME : spi_pkg::ST_DONE;
				else
					state_n = spi_pkg::ST_CUR;
			end
			spi_pkg::ST_DONE: begin
				if (slot_free)
					state_n = spi_pkg::ST_IDLE;
			end
			default: state_n = spi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.seg  = seg_q;
		cmd.mid  = mid_q;
		cmd.ph   = ph_q;
		in_ready = 1'b0;
		raddr    = idx_q[AW-1:0];
		unique case (state_q)
			spi_pkg::ST_IDLE: begin
				in_ready        = 1'b1;
				cmd.latch_query = accept;
			end
			spi_pkg::ST_APPEND: cmd.wr = !full;
			spi_pkg::ST_PRIME: begin
				cmd.clr_par = 1'b1;
				raddr       = last[AW-1:0];
			end
			spi_pkg::ST_LATCHP: cmd.latch_prev = 1'b1;
			spi_pkg::ST_CUR:    cmd.latch_cur  = 1'b1;
			spi_pkg::ST_OPR:    cmd.op_load    = 1'b1;
			spi_pkg::ST_MUL:    cmd.mul        = 1'b1;
			spi_pkg::ST_SUB:    cmd.sub        = 1'b1;
			spi_pkg::ST_EVAL: begin
				cmd.eval       = 1'b1;
				cmd.shift_prev = 1'b1;
				raddr          = idx_n[AW-1:0];
			end
			spi_pkg::ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= spi_pkg::ST_IDLE;
			kind_q       <= spi_pkg::KIND_APPEND;
			count_q      <= '0;
			idx_q        <= '0;
			ph_q         <= spi_pkg::PH_CR;
			seg_q        <= 1'b0;
			mid_q        <= 1'b0;
			res_hit_q    <= 1'b0;
			res_status_q <= 1'b0;
			out_valid_q  <= 1'b0;
			hit_q        <= 1'b0;
			status_q     <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == spi_pkg::ST_DONE && slot_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				spi_pkg::ST_IDLE: begin
					if (accept) begin
						kind_q       <= kind;
						res_hit_q    <= 1'b0;
						res_status_q <= 1'b0;
						seg_q        <= (kind == spi_pkg::KIND_SEG);
						mid_q        <= 1'b0;
						if (kind == spi_pkg::KIND_CLEAR)
							count_q <= '0;
					end
				end
				spi_pkg::ST_APPEND: begin
					if (full)
						res_status_q <= 1'b1;
					else
						count_q <= count_q + 1'b1;
				end
				spi_pkg::ST_PRIME: idx_q <= '0;
				spi_pkg::ST_CUR:   ph_q  <= spi_pkg::PH_CR;
				spi_pkg::ST_SUB:   ph_q  <= ph_q + 1'b1;
				spi_pkg::ST_EVAL: begin
					idx_q <= idx_n;
					if (seg_q && stat.seg_cross) begin
						res_hit_q <= 1'b1;
					end else if (walk_end) begin
						if (seg_q) begin
							seg_q <= 1'b0;
							mid_q <= 1'b1;
						end else begin
							res_hit_q <= stat.par_next;
						end
					end
				end
				spi_pkg::ST_DONE: begin
					if (slot_free) begin
						hit_q       <= res_hit_q && (kind_q == spi_pkg::KIND_POINT
							|| kind_q == spi_pkg::KIND_SEG);
						status_q    <= res_status_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign status    = status_q;

endmodule

// ===== rtl/core/spi_dp.sv =====
// Datapath for the segment/polygon intersection unit: vertex store, query
// registers, cross-product multipliers and edge evaluation. Depends on spi_pkg.
module spi_dp #(
	parameter int MAX_VERTICES = spi_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = spi_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [spi_pkg::FIELD_W-1:0]          x1,
	input  logic [spi_pkg::FIELD_W-1:0]          y1,
	input  logic [spi_pkg::FIELD_W-1:0]          x2,
	input  logic [spi_pkg::FIELD_W-1:0]          y2,
	input  spi_pkg::cmd_t                        cmd,
	output spi_pkg::stat_t                       stat,
	input  logic [$clog2(MAX_VERTICES)-1:0]      waddr,
	input  logic [$clog2(MAX_VERTICES)-1:0]      raddr
);

	localparam int W  = (COORD_WIDTH < spi_pkg::FIELD_W) ? COORD_WIDTH : spi_pkg::FIELD_W;
	localparam int EW = W + 2;
	localparam int PW = 2 * EW;
	localparam int RW = PW + 1;

	logic signed [W-1:0] mem_x [MAX_VERTICES];
	logic signed [W-1:0] mem_y [MAX_VERTICES];
	logic signed [W-1:0] rd_x_q, rd_y_q;

	logic signed [W-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [W-1:0] px_q, py_q, cx_q, cy_q;
	logic signed [EW-1:0] opa_q, opb_q, opc_q, opd_q;
	logic signed [PW-1:0] pa_q, pb_q;
	logic signed [RW-1:0] cr_q, tn_q, un_q;
	logic par_q;

	logic signed [EW-1:0] qx, qy, vcx, vcy, vpx, vpy;
	logic signed [EW-1:0] d1x, d1y, d2x, d2y, ex, ey, dy;
	logic signed [EW-1:0] na, nb, nc, nd;
	logic signed [RW-1:0] diff;
	logic straddle, toggle, pos_ok, neg_ok;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_x[waddr] <= ax_q;
			mem_y[waddr] <= ay_q;
		end
		rd_x_q <= mem_x[raddr];
		rd_y_q <= mem_y[raddr];
	end

	assign qx  = cmd.mid ? (EW'(ax_q) + EW'(bx_q)) : EW'(ax_q);
	assign qy  = cmd.mid ? (EW'(ay_q) + EW'(by_q)) : EW'(ay_q);
	assign vcx = cmd.mid ? (EW'(cx_q) <<< 1) : EW'(cx_q);
	assign vcy = cmd.mid ? (EW'(cy_q) <<< 1) : EW'(cy_q);
	assign vpx = cmd.mid ? (EW'(px_q) <<< 1) : EW'(px_q);
	assign vpy = cmd.mid ? (EW'(py_q) <<< 1) : EW'(py_q);

	assign d1x = EW'(bx_q) - EW'(ax_q);
	assign d1y = EW'(by_q) - EW'(ay_q);
	assign d2x = EW'(px_q) - EW'(cx_q);
	assign d2y = EW'(py_q) - EW'(cy_q);
	assign ex  = EW'(cx_q) - EW'(ax_q);
	assign ey  = EW'(cy_q) - EW'(ay_q);
	assign dy  = vpy - vcy;

	always_comb begin
		na = qx - vcx;
		nb = dy;
		nc = vpx - vcx;
		nd = qy - vcy;
		if (cmd.seg) begin
			case (cmd.ph)
				spi_pkg::PH_CR: begin
					na = d1x; nb = d2y; nc = d1y; nd = d2x;
				end
				spi_pkg::PH_TN: begin
					na = ex;  nb = d2y; nc = ey;  nd = d2x;
				end
				default: begin
					na = ex;  nb = d1y; nc = ey;  nd = d1x;
				end
			endcase
		end
	end

	assign diff = RW'(pa_q) - RW'(pb_q);

	always_ff @(posedge clk) begin
		if (cmd.latch_query) begin
			ax_q <= x1[W-1:0];
			ay_q <= y1[W-1:0];
			bx_q <= x2[W-1:0];
			by_q <= y2[W-1:0];
		end
		if (cmd.latch_prev) begin
			px_q <= rd_x_q;
			py_q <= rd_y_q;
		end else if (cmd.shift_prev) begin
			px_q <= cx_q;
			py_q <= cy_q;
		end
		if (cmd.latch_cur) begin
			cx_q <= rd_x_q;
			cy_q <= rd_y_q;
		end
		if (cmd.op_load) begin
			opa_q <= na;
			opb_q <= nb;
			opc_q <= nc;
			opd_q <= nd;
		end
		if (cmd.mul) begin
			pa_q <= opa_q * opb_q;
			pb_q <= opc_q * opd_q;
		end
		if (cmd.sub) begin
			case (cmd.ph)
				spi_pkg::PH_CR: cr_q <= diff;
				spi_pkg::PH_TN: tn_q <= diff;
				default:        un_q <= diff;
			endcase
		end
	end

	assign straddle = (vcy > qy) != (vpy > qy);
	assign toggle   = straddle && ((dy > 0) ? (cr_q < 0) : (cr_q > 0));
	assign pos_ok   = (cr_q > 0) && (tn_q >= 0) && (tn_q <= cr_q)
		&& (un_q >= 0) && (un_q <= cr_q);
	assign neg_ok   = (cr_q < 0) && (tn_q <= 0) && (tn_q >= cr_q)
		&& (un_q <= 0) && (un_q >= cr_q);

	assign stat.seg_cross = pos_ok || neg_ok;
	assign stat.par_next  = par_q ^ toggle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			par_q <= 1'b0;
		else if (cmd.clr_par)
			par_q <= 1'b0;
		else if (cmd.eval && !cmd.seg)
			par_q <= stat.par_next;
	end

endmodule

// ===== rtl/core/segment_polygon_intersect_unit.sv =====
// Append and clear need no edge walk. A point query walks the stored vertices
// one edge at a time through the shared multiplier pair. A segment query makes
// an edge pass, plus a midpoint pass when no edge is crossed. One word in flight
// at a time. Reset (arst_n low, asynchronous) empties the polygon and the output
// register; the vertex store is not cleared.
module segment_polygon_intersect_unit #(
	parameter int MAX_VERTICES = spi_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = spi_pkg::COORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   kind,
	input  logic [spi_pkg::FIELD_W-1:0]  x1,
	input  logic [spi_pkg::FIELD_W-1:0]  y1,
	input  logic [spi_pkg::FIELD_W-1:0]  x2,
	input  logic [spi_pkg::FIELD_W-1:0]  y2,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic                         status
);

	localparam int AW = $clog2(MAX_VERTICES);

	spi_pkg::cmd_t  cmd;
	spi_pkg::stat_t stat;
	logic [AW-1:0]  waddr, raddr;

	spi_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.status(status),
		.cmd(cmd),
		.stat(stat),
		.waddr(waddr),
		.raddr(raddr)
	);

	spi_dp #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_WIDTH(COORD_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.x1(x1),
		.y1(y1),
		.x2(x2),
		.y2(y2),
		.cmd(cmd),
		.stat(stat),
		.waddr(waddr),
		.raddr(raddr)
	);

endmodule

// ===== rtl/core/spi_chk.sv =====
// Port-level checker for segment_polygon_intersect_unit, bound to the top level.
// Depends on nothing but the top level's ports.
module spi_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic hit,
	input logic status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(status))
		else $error("result dropped or changed while stalled");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while one is in flight");

	a_status_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !hit)
		else $error("dropped append reports a hit");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result shown right after reset");

endmodule

bind segment_polygon_intersect_unit spi_chk u_spi_chk (.*);

// ===== sim/segment_polygon_intersect_unit_test.sv =====
// Self-checking testbench for segment_polygon_intersect_unit: directed table, then random
// polygon loads, point and segment queries, checked against an exact integer predictor.
// Depends on spi_pkg and the top-level RTL.
module segment_polygon_intersect_unit_test;

	localparam int NV = spi_pkg::MAX_VERTICES_DEF;
	localparam longint LIMIT = 3000000;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] x1, y1, x2, y2;
	} word_t;

	typedef struct packed {
		logic hit;
		logic status;
	} answer_t;

	typedef struct {
		word_t w;
		logic known;
		answer_t ans;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] kind;
	logic [31:0] x1, y1, x2, y2;
	logic hit, status;

	segment_polygon_intersect_unit dut (.*);

	longint poly_x[NV], poly_y[NV];
	int poly_n;
	answer_t answers_due[$];
	int errors;
	longint cycles;
	row_t rows[$];

	task automatic report(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	function automatic int sgn(input logic signed [127:0] v);
		return v < 0 ? -1 : (v == 0 ? 0 : 1);
	endfunction

	function automatic logic parity_inside(input longint qx, input longint qy,
			input longint sc);
		logic ins;
		longint xi, yi, xj, yj, dy;
		int j, s;
		logic signed [127:0] a, b;
		ins = 0;
		for (int i = 0; i < poly_n; i++) begin
			j = (i == 0) ? poly_n - 1 : i - 1;
			xi = poly_x[i] * sc; yi = poly_y[i] * sc;
			xj = poly_x[j] * sc; yj = poly_y[j] * sc;
			if ((yi > qy) != (yj > qy)) begin
				dy = yj - yi;
				a = 128'(qx - xi) * 128'(dy);
				b = 128'(xj - xi) * 128'(qy - yi);
				s = sgn(a - b);
				if ((dy > 0) ? (s < 0) : (s > 0))
					ins = !ins;
			end
		end
		return ins;
	endfunction

	function automatic logic signed [127:0] cross2(input longint ax, ay, bx, by);
		return 128'(ax) * 128'(by) - 128'(ay) * 128'(bx);
	endfunction

	function automatic logic edges_cross(input longint ax, ay, bx, by, cx, cy, dx, dy);
		logic signed [127:0] cr, tn, un;
		cr = cross2(bx - ax, by - ay, dx - cx, dy - cy);
		if (cr == 0)
			return 0;
		tn = cross2(cx - ax, cy - ay, dx - cx, dy - cy);
		un = cross2(cx - ax, cy - ay, bx - ax, by - ay);
		if (cr < 0) begin
			cr = -cr; tn = -tn; un = -un;
		end
		return tn >= 0 && cr - tn >= 0 && un >= 0 && cr - un >= 0;
	endfunction

	function automatic answer_t polygon_answer(input word_t w);
		answer_t r;
		longint ax, ay, bx, by;
		logic any;
		int j;
		r = '0;
		ax = longint'($signed(w.x1)); ay = longint'($signed(w.y1));
		bx = longint'($signed(w.x2)); by = longint'($signed(w.y2));
		case (w.kind)
			spi_pkg::KIND_APPEND: begin
				if (poly_n < NV) begin
					poly_x[poly_n] = ax; poly_y[poly_n] = ay; poly_n++;
				end else
					r.status = 1;
			end
			spi_pkg::KIND_POINT: r.hit = parity_inside(ax, ay, 1);
			spi_pkg::KIND_SEG: begin
				any = 0;
				for (int i = 0; i < poly_n && !any; i++) begin
					j = (i == 0) ? poly_n - 1 : i - 1;
					any = edges_cross(ax, ay, bx, by, poly_x[i], poly_y[i],
						poly_x[j], poly_y[j]);
				end
				if (!any)
					any = parity_inside(ax + bx, ay + by, 2);
				r.hit = any;
			end
			default: poly_n = 0;
		endcase
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stall per word, check on accept
	initial begin
		int gap;
		answer_t got, want;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0)
				gap = 0;
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!(out_valid && out_ready));
			got = '{hit, status};
			if (answers_due.size() == 0)
				report("result with nothing due");
			else begin
				want = answers_due.pop_front();
				if (got.hit !== want.hit)
					report($sformatf("hit %b want %b", got.hit, want.hit));
				if (got.status !== want.status)
					report($sformatf("status %b want %b", got.status, want.status));
			end
		end
	end

	task automatic send(input word_t w, input int gap);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		{kind, x1, y1, x2, y2} <= w;
		do @(posedge clk); while (!(in_valid && in_ready));
		answers_due.push_back(polygon_answer(w));
	endtask

	function automatic logic [31:0] rcoord(input int span);
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(0, 2 * span)) - span);
		endcase
	endfunction

	function automatic word_t rword(input logic [1:0] k, input int span);
		return '{k, rcoord(span), rcoord(span), rcoord(span), rcoord(span)};
	endfunction

	initial begin
		word_t w;
		int nverts, gap;
		logic [31:0] MX, MN;
		MX = 32'h7FFFFFFF; MN = 32'h80000000;
		errors = 0; cycles = 0; poly_n = 0;
		arst_n = 0; in_valid = 0; kind = spi_pkg::KIND_APPEND;
		x1 = 0; y1 = 0; x2 = 0; y2 = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		rows.push_back('{'{spi_pkg::KIND_POINT, 32'd0, 32'd0, 32'd0, 32'd0}, 1, '{0, 0}});
		rows.push_back('{'{spi_pkg::KIND_SEG, MN, MN, MX, MX}, 1, '{0, 0}});
		rows.push_back('{'{spi_pkg::KIND_APPEND, MN, MN, 32'd0, 32'd0}, 1, '{0, 0}});
		rows.push_back('{'{spi_pkg::KIND_APPEND, MX, MN, 32'd0, 32'd0}, 1, '{0, 0}});
		rows.push_back('{'{spi_pkg::KIND_APPEND, MX, MX, 32'd0, 32'd0}, 1, '{0, 0}});
		rows.push_back('{'{spi_pkg::KIND_APPEND, MN, MX, 32'd0, 32'd0}, 1, '{0, 0}});
		rows.push_back('{'{spi_pkg::KIND_POINT, 32'd0, 32'd0, 32'd0, 32'd0}, 0, '0});
		rows.push_back('{'{spi_pkg::KIND_POINT, MN, MN, 32'd0, 32'd0}, 0, '0});
		rows.push_back('{'{spi_pkg::KIND_POINT, MX, MX, 32'd0, 32'd0}, 0, '0});
		rows.push_back('{'{spi_pkg::KIND_SEG, MN, MN, MX, MX}, 0, '0});
		rows.push_back('{'{spi_pkg::KIND_SEG, MN, 32'd0, MN, 32'd5}, 0, '0});
		rows.push_back('{'{spi_pkg::KIND_SEG, 32'd1, 32'd1, 32'd2, 32'd2}, 0, '0});
		rows.push_back('{'{spi_pkg::KIND_SEG, 32'd3, 32'd3, 32'd3, 32'd3}, 0, '0});
		rows.push_back('{'{spi_pkg::KIND_CLEAR, MX, MX, MX, MX}, 1, '{0, 0}});
		rows.push_back('{'{spi_pkg::KIND_APPEND, 32'd10, 32'd10, 32'd0, 32'd0}, 1, '{0, 0}});
		rows.push_back('{'{spi_pkg::KIND_POINT, 32'd10, 32'd10, 32'd0, 32'd0}, 0, '0});
		rows.push_back('{'{spi_pkg::KIND_APPEND, 32'hFFFFFFF6, 32'd10, 32'd0, 32'd0}, 1,
			'{0, 0}});
		rows.push_back('{'{spi_pkg::KIND_SEG, 32'd0, 32'd0, 32'd0, 32'd20}, 0, '0});
		rows.push_back('{'{spi_pkg::KIND_POINT, 32'd0, 32'd10, 32'd0, 32'd0}, 0, '0});
		foreach (rows[i]) begin
			if (rows[i].known) begin
				w = rows[i].w;
				if (polygon_answer(w) !== rows[i].ans)
					report($sformatf("table row %0d", i));
				// undo the state change of the preview call
				if (w.kind == spi_pkg::KIND_APPEND) poly_n--;
			end
		end
		poly_n = 0;
		foreach (rows[i])
			send(rows[i].w, $urandom_range(0, 5));

		// fill the store and overflow it
		send('{spi_pkg::KIND_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0}, 0);
		for (int i = 0; i < NV + 2; i++)
			send(rword(spi_pkg::KIND_APPEND, 1000), 0);
		send(rword(spi_pkg::KIND_POINT, 1000), 0);
		send(rword(spi_pkg::KIND_SEG, 1000), 0);

		// hold until every answer is back
		in_valid <= 0;
		wait (answers_due.size() == 0);
		@(posedge clk);

		for (int n = 0; n < 1150;) begin
			int span;
			span = ($urandom_range(0, 1) != 0) ? 50 : 1000000000;
			nverts = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
				$urandom_range(3, 10);
			send('{spi_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom},
				$urandom_range(0, 5));
			for (int i = 0; i < nverts; i++) begin
				send(rword(spi_pkg::KIND_APPEND, span), $urandom_range(0, 5));
				n++;
			end
			repeat ($urandom_range(2, 8)) begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
				w = rword($urandom_range(0, 3) == 0 ? spi_pkg::KIND_POINT :
					spi_pkg::KIND_SEG, span);
				if ($urandom_range(0, 9) == 0)
					w.kind = 2'($urandom_range(0, 3));
				send(w, gap);
				n++;
			end
			n++;
		end

		in_valid <= 0;
		wait (answers_due.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
